// File: design/mfpc_pkg.sv
// Shared types and constants for the motor fader position controller.
package mfpc_pkg;

	localparam int POS_W      = 12;
	localparam int LEVEL_W    = 8;
	localparam int TIME_W     = 16;
	localparam int STATUS_W   = 3;
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 3;
	localparam int NEAR_LIMIT = 30;
	localparam int NUM_W      = 20;

	localparam logic [OP_W-1:0] OP_START  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MOVING  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ARRIVED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

	localparam logic [ADDR_W-1:0] REG_DEAD_BAND  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_SPEED_LO   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_SPEED_HI   = 3'd2;
	localparam logic [ADDR_W-1:0] REG_NEAR_SPEED = 3'd3;
	localparam logic [ADDR_W-1:0] REG_TIMEOUT    = 3'd4;

	localparam logic [LEVEL_W-1:0] RST_DEAD_BAND  = 8'd2;
	localparam logic [LEVEL_W-1:0] RST_SPEED_LO   = 8'd150;
	localparam logic [LEVEL_W-1:0] RST_SPEED_HI   = 8'd255;
	localparam logic [LEVEL_W-1:0] RST_NEAR_SPEED = 8'd100;
	localparam logic [TIME_W-1:0]  RST_TIMEOUT    = 16'd10000;

	typedef struct packed {
		logic [LEVEL_W-1:0] dead_band;
		logic [LEVEL_W-1:0] speed_lo;
		logic [LEVEL_W-1:0] speed_hi;
		logic [LEVEL_W-1:0] near_speed;
		logic [TIME_W-1:0]  timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic                on;
		logic                dir;
		logic                busy;
		logic [STATUS_W-1:0] status;
		logic                set_level;
		logic                near;
		logic [NUM_W-1:0]    far_num;
	} ctrl_t;

endpackage

// File: design/mfpc_if.sv
// Handshake channel interfaces for commands, results and register writes.
interface mfpc_cmd_if import mfpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [POS_W-1:0] target;
	logic [POS_W-1:0] position;

	modport source (output valid, output op, output target, output position, input ready);
	modport sink (input valid, input op, input target, input position, output ready);
endinterface

interface mfpc_res_if import mfpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                pin_forward;
	logic                pin_reverse;
	logic [LEVEL_W-1:0]  speed;
	logic                busy_res;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output pin_forward, output pin_reverse, output speed,
		output busy_res, output status, input ready);
	modport sink (input valid, input pin_forward, input pin_reverse, input speed,
		input busy_res, input status, output ready);
endinterface

interface mfpc_cfg_if import mfpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [TIME_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// File: design/mfpc_ctrl.sv
// Move state and per-word control decision of the fader controller.
module mfpc_ctrl import mfpc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             update,
	input  logic [OP_W-1:0]  op,
	input  logic [POS_W-1:0] target,
	input  logic [POS_W-1:0] position,
	input  cfg_t             cfg,
	output ctrl_t            decision
);

	localparam int CMP_W = (ADC_BITS > POS_W) ? ADC_BITS : POS_W;
	localparam logic [CMP_W-1:0] ADC_MAX_V = CMP_W'((1 << ADC_BITS) - 1);

	logic              moving_q;
	logic              driven_q;
	logic              dir_q;
	logic [POS_W-1:0]  goal_q;
	logic [TIME_W-1:0] elapsed_q;

	logic              moving_d;
	logic              driven_d;
	logic              dir_d;
	logic [POS_W-1:0]  goal_d;
	logic [TIME_W-1:0] elapsed_d;

	logic              fwd;
	logic [POS_W-1:0]  gap;
	logic [POS_W-1:0]  far_dist;
	logic [LEVEL_W-1:0] span;
	logic              arrived;
	logic              timed_out;
	logic              at_end;

	always_comb begin
		fwd       = goal_q > position;
		gap       = fwd ? (goal_q - position) : (position - goal_q);
		far_dist  = gap - POS_W'(NEAR_LIMIT);
		span      = cfg.speed_hi - cfg.speed_lo;
		arrived   = gap <= POS_W'(cfg.dead_band);
		timed_out = elapsed_q > cfg.timeout_ms;
		at_end    = (!fwd && (position == '0)) || (fwd && (CMP_W'(position) >= ADC_MAX_V));
	end

	always_comb begin
		moving_d  = moving_q;
		driven_d  = driven_q;
		dir_d     = dir_q;
		goal_d    = goal_q;
		elapsed_d = elapsed_q;

		decision.on        = driven_q && moving_q;
		decision.dir       = dir_q;
		decision.busy      = moving_q;
		decision.status    = moving_q ? ST_MOVING : ST_IDLE;
		decision.set_level = 1'b0;
		decision.near      = gap < POS_W'(NEAR_LIMIT);
		decision.far_num   = NUM_W'(far_dist) * NUM_W'(span);

		case (op)
			OP_START: begin
				moving_d        = 1'b1;
				driven_d        = 1'b0;
				dir_d           = 1'b0;
				goal_d          = target;
				elapsed_d       = '0;
				decision.on     = 1'b0;
				decision.dir    = 1'b0;
				decision.busy   = 1'b1;
				decision.status = ST_MOVING;
			end
			OP_SAMPLE: begin
				if (moving_q) begin
					if (arrived || timed_out || at_end) begin
						moving_d        = 1'b0;
						driven_d        = 1'b0;
						dir_d           = 1'b0;
						decision.on     = 1'b0;
						decision.dir    = 1'b0;
						decision.busy   = 1'b0;
						if (arrived) begin
							decision.status = ST_ARRIVED;
						end else if (timed_out) begin
							decision.status = ST_TIMEOUT;
						end else begin
							decision.status = ST_RANGE;
						end
					end else begin
						driven_d           = 1'b1;
						dir_d              = fwd;
						decision.on        = 1'b1;
						decision.dir       = fwd;
						decision.set_level = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (elapsed_q != '1) begin
					elapsed_d = elapsed_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q  <= 1'b0;
			driven_q  <= 1'b0;
			dir_q     <= 1'b0;
			goal_q    <= '0;
			elapsed_q <= '0;
		end else if (update) begin
			moving_q  <= moving_d;
			driven_q  <= driven_d;
			dir_q     <= dir_d;
			goal_q    <= goal_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

// File: design/motor_fader_position_controller_top.sv
// Top level of the motor fader position controller with its speed mapping pipeline.
// A command word passes the input, decision, multiply and output registers to its result.
// Throughput: one word per cycle unless stalled; a stage holds only while the next stalls.
// The speed map divides by a constant through a registered reciprocal multiply.
// Reset clears the move state, the pipeline valid bits and loads the register defaults.
// Register writes are taken in every cycle; the write port never stalls.
module motor_fader_position_controller_top import mfpc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input logic        clk,
	input logic        arst_n,
	mfpc_cmd_if.sink   cmd,
	mfpc_res_if.source res,
	mfpc_cfg_if.sink   cfg
);

	localparam int ADC_MAX_I = (1 << ADC_BITS) - 1;
	localparam int DIVISOR   = ADC_MAX_I - NEAR_LIMIT;
	localparam int LOG_D     = $clog2(DIVISOR);
	localparam int SHIFT     = NUM_W + LOG_D;
	localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
		/ longint'(DIVISOR);
	localparam int REC_W     = NUM_W + 1;
	localparam int PROD_W    = NUM_W + REC_W;
	localparam int QW        = PROD_W - SHIFT;
	localparam int SUM_W     = ((QW > LEVEL_W) ? QW : LEVEL_W) + 1;
	localparam logic [REC_W-1:0] RECIP_V = REC_W'(RECIP);

	cfg_t cfg_q;

	logic             v1_q;
	logic [OP_W-1:0]  op_s1;
	logic [POS_W-1:0] target_s1;
	logic [POS_W-1:0] position_s1;

	logic  v2_q;
	ctrl_t ctrl_s2;
	logic  v3_q;
	ctrl_t ctrl_s3;
	logic [PROD_W-1:0] prod_s3;

	logic               vo_q;
	logic               pin_fwd_q;
	logic               pin_rev_q;
	logic [LEVEL_W-1:0] speed_q;
	logic               busy_q;
	logic [STATUS_W-1:0] status_q;
	logic [LEVEL_W-1:0] last_level_q;

	logic  rdy1;
	logic  rdy2;
	logic  rdy3;
	logic  rdy4;
	ctrl_t decision;

	logic [QW-1:0]      quot;
	logic [SUM_W-1:0]   far_sum;
	logic [LEVEL_W-1:0] far_level;
	logic [LEVEL_W-1:0] level_c;

	assign rdy4      = !vo_q || res.ready;
	assign rdy3      = !v3_q || rdy4;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign cmd.ready = rdy1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_band  <= RST_DEAD_BAND;
			cfg_q.speed_lo   <= RST_SPEED_LO;
			cfg_q.speed_hi   <= RST_SPEED_HI;
			cfg_q.near_speed <= RST_NEAR_SPEED;
			cfg_q.timeout_ms <= RST_TIMEOUT;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_DEAD_BAND:  cfg_q.dead_band  <= cfg.data[LEVEL_W-1:0];
				REG_SPEED_LO:   cfg_q.speed_lo   <= cfg.data[LEVEL_W-1:0];
				REG_SPEED_HI:   cfg_q.speed_hi   <= cfg.data[LEVEL_W-1:0];
				REG_NEAR_SPEED: cfg_q.near_speed <= cfg.data[LEVEL_W-1:0];
				REG_TIMEOUT:    cfg_q.timeout_ms <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	mfpc_ctrl #(
		.ADC_BITS (ADC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (v1_q && rdy2),
		.op       (op_s1),
		.target   (target_s1),
		.position (position_s1),
		.cfg      (cfg_q),
		.decision (decision)
	);

	always_comb begin
		quot    = prod_s3[PROD_W-1:SHIFT];
		far_sum = SUM_W'(cfg_q.speed_lo) + SUM_W'(quot);
		if (cfg_q.speed_hi <= cfg_q.speed_lo) begin
			far_level = cfg_q.speed_lo;
		end else if (far_sum > SUM_W'(8'hFF)) begin
			far_level = '1;
		end else begin
			far_level = far_sum[LEVEL_W-1:0];
		end
		level_c = ctrl_s3.near ? cfg_q.near_speed : far_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= cmd.valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1       <= cmd.op;
			target_s1   <= cmd.target;
			position_s1 <= cmd.position;
		end
		if (rdy2) begin
			ctrl_s2 <= decision;
		end
		if (rdy3) begin
			ctrl_s3 <= ctrl_s2;
			prod_s3 <= PROD_W'(ctrl_s2.far_num) * PROD_W'(RECIP_V);
		end
		if (rdy4) begin
			pin_fwd_q <= ctrl_s3.on && !ctrl_s3.dir;
			pin_rev_q <= ctrl_s3.on && ctrl_s3.dir;
			busy_q    <= ctrl_s3.busy;
			status_q  <= ctrl_s3.status;
			if (!ctrl_s3.on) begin
				speed_q <= '0;
			end else if (ctrl_s3.set_level) begin
				speed_q <= level_c;
			end else begin
				speed_q <= last_level_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
		end else if (v3_q && rdy4 && ctrl_s3.set_level) begin
			last_level_q <= level_c;
		end
	end

	assign res.valid       = vo_q;
	assign res.pin_forward = pin_fwd_q;
	assign res.pin_reverse = pin_rev_q;
	assign res.speed       = speed_q;
	assign res.busy_res    = busy_q;
	assign res.status      = status_q;

	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.pin_forward && res.pin_reverse))
		else $error("Both drive pins active in one result word.");

	a_drive_implies_moving: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.pin_forward || res.pin_reverse) |-> res.busy_res
		&& (res.status == ST_MOVING))
		else $error("Drive pins active without a move in progress.");

	a_stop_drives_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && ((res.status == ST_ARRIVED) || (res.status == ST_TIMEOUT)
		|| (res.status == ST_RANGE)) |-> !res.busy_res && (res.speed == '0))
		else $error("Stopped move still reports drive or busy.");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v1_q)
		else $error("Accepted command word missing from the input stage.");

endmodule
